/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the profile sampler.
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

/* hdl/tps_pkg.sv */
// Shared types and constants of the trapezoidal profile sampler.
// No dependencies.
package tps_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int MID_DEPTH_DEF = 4;
	localparam int OUT_DEPTH_DEF = 4;

	localparam logic [1:0] REG_MAX_VELOCITY     = 2'd0;
	localparam logic [1:0] REG_MAX_ACCELERATION = 2'd1;
	localparam logic [1:0] REG_MOVE_DISTANCE    = 2'd2;

	typedef enum logic [2:0] {
		PH_NEG,
		PH_DONE,
		PH_ACC,
		PH_DEC,
		PH_CRU
	} phase_t;

	// profile from regs; user keeps it stable while samples are in flight
	typedef struct packed {
		logic [30:0] acc_mag;
		logic [31:0] vp;
		logic [31:0] dist_mag;
		logic        rev;
		logic [63:0] t0;
		logic [63:0] t1;
		logic [63:0] t2;
		logic [63:0] base;
	} profile_t;

	// classified sample: phase and the time operand of the multiplies
	typedef struct packed {
		phase_t      phase;
		logic [30:0] x;
	} item_t;

	typedef struct packed {
		logic [31:0] pos;
		logic [31:0] vel;
		logic [31:0] acc;
	} result_t;

	function automatic logic [31:0] apply_sign(input logic [31:0] mag, input logic neg);
		apply_sign = neg ? (~mag + 32'd1) : mag;
	endfunction

endpackage

/* hdl/tps_fifo.sv */
// Small register FIFO used as the queue between front and back and as the
// result queue. Depends on nothing.
module tps_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [W-1:0]               wdata,
	input  logic                       pop,
	output logic [W-1:0]               rdata,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output logic                       empty,
	output logic                       full
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		next_ptr = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

/* hdl/tps_setup.sv */
// Configuration registers and the sequential planner that derives the
// phase times of the profile. Depends on tps_pkg.
module tps_setup #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [31:0]       wr_data,
	output logic              busy,
	output tps_pkg::profile_t prof
);
	import tps_pkg::*;

	typedef enum logic [3:0] {
		S_MUL_DA,
		S_MUL_VV,
		S_CMP,
		S_SQRT,
		S_DIV_Q,
		S_TC_SET,
		S_DIV_TC,
		S_DIV_TA,
		S_SUM_T1,
		S_SUM_T2,
		S_BASE,
		S_IDLE
	} state_t;

	state_t      state_q;
	logic [30:0] vel_q, acc_q;
	logic [31:0] md_q;
	logic [30:0] v_eff, a_eff;
	logic [31:0] dist_mag;
	logic [63:0] da_q, vv_q;
	logic [31:0] vp_q;
	logic [63:0] tc_q, t0_q, t1_q, t2_q, base_q, plo_q, phi_q;
	logic [5:0]  cnt_q;
	logic        restart;
	// shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	// restoring divider
	logic [63:0] div_num_q, div_quo_q, quo_nx;
	logic [31:0] div_den_q;
	logic [32:0] div_rem_q, rem_sh, rem_nx;
	logic        div_ge;
	// digit-by-digit square root
	logic [63:0] rad_q;
	logic [31:0] root_q, root_nx;
	logic [35:0] srem_q, srem_sh, trial;
	logic        sq_ge;
	logic [31:0] diff;

	assign v_eff    = (vel_q == '0) ? 31'd1 : vel_q;
	assign a_eff    = (acc_q == '0) ? 31'd1 : acc_q;
	assign dist_mag = md_q[31] ? (~md_q + 32'd1) : md_q;

	// any write to a defined register starts a new plan
	assign restart = wr_en && (wr_index == REG_MAX_VELOCITY
		|| wr_index == REG_MAX_ACCELERATION || wr_index == REG_MOVE_DISTANCE);

	always_comb begin
		unique case (state_q)
			S_MUL_DA: begin
				mul_a = dist_mag;
				mul_b = {1'b0, a_eff};
			end
			S_MUL_VV: begin
				mul_a = {1'b0, v_eff};
				mul_b = {1'b0, v_eff};
			end
			S_SUM_T1: begin
				mul_a = vp_q;
				mul_b = t0_q[31:0];
			end
			S_SUM_T2: begin
				mul_a = vp_q;
				mul_b = t0_q[63:32];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod = {32'b0, mul_a} * {32'b0, mul_b};

	assign rem_sh = {div_rem_q[31:0], div_num_q[63]};
	assign div_ge = (rem_sh >= {1'b0, div_den_q});
	assign rem_nx = div_ge ? (rem_sh - {1'b0, div_den_q}) : rem_sh;
	assign quo_nx = {div_quo_q[62:0], div_ge};

	assign srem_sh = {srem_q[33:0], rad_q[63:62]};
	assign trial   = {2'b0, root_q, 2'b01};
	assign sq_ge   = (srem_sh >= trial);
	assign root_nx = {root_q[30:0], sq_ge};

	// trapezoid: vv/a never exceeds the distance
	assign diff = dist_mag - div_quo_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_MUL_DA;
			vel_q     <= 31'(1) << FRAC_BITS;
			acc_q     <= 31'(1) << FRAC_BITS;
			md_q      <= '0;
			cnt_q     <= '0;
			da_q      <= '0;
			vv_q      <= '0;
			vp_q      <= '0;
			tc_q      <= '0;
			t0_q      <= '0;
			t1_q      <= '0;
			t2_q      <= '0;
			base_q    <= '0;
			plo_q     <= '0;
			phi_q     <= '0;
			div_num_q <= '0;
			div_quo_q <= '0;
			div_den_q <= '0;
			div_rem_q <= '0;
			rad_q     <= '0;
			root_q    <= '0;
			srem_q    <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_MAX_VELOCITY:     vel_q <= wr_data[30:0];
					REG_MAX_ACCELERATION: acc_q <= wr_data[30:0];
					REG_MOVE_DISTANCE:    md_q  <= wr_data;
					default:              ;
				endcase
			end

			if (restart) begin
				state_q <= S_MUL_DA;
			end else begin
				unique case (state_q)
					S_MUL_DA: begin
						da_q    <= prod;
						state_q <= S_MUL_VV;
					end
					S_MUL_VV: begin
						vv_q    <= prod;
						state_q <= S_CMP;
					end
					S_CMP: begin
						cnt_q <= '0;
						if (da_q < vv_q) begin
							rad_q   <= da_q;
							root_q  <= '0;
							srem_q  <= '0;
							tc_q    <= '0;
							state_q <= S_SQRT;
						end else begin
							vp_q      <= {1'b0, v_eff};
							div_num_q <= vv_q;
							div_den_q <= {1'b0, a_eff};
							div_rem_q <= '0;
							state_q   <= S_DIV_Q;
						end
					end
					S_SQRT: begin
						rad_q  <= {rad_q[61:0], 2'b00};
						srem_q <= sq_ge ? (srem_sh - trial) : srem_sh;
						root_q <= root_nx;
						if (cnt_q == 6'd31) begin
							vp_q      <= root_nx;
							div_num_q <= 64'(root_nx) << FRAC_BITS;
							div_den_q <= {1'b0, a_eff};
							div_rem_q <= '0;
							cnt_q     <= '0;
							state_q   <= S_DIV_TA;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					S_DIV_Q, S_DIV_TC, S_DIV_TA: begin
						div_quo_q <= quo_nx;
						if (cnt_q == 6'd63) begin
							cnt_q <= '0;
							if (state_q == S_DIV_Q) begin
								state_q <= S_TC_SET;
							end else if (state_q == S_DIV_TC) begin
								tc_q      <= quo_nx;
								div_num_q <= 64'(vp_q) << FRAC_BITS;
								div_den_q <= {1'b0, a_eff};
								div_rem_q <= '0;
								state_q   <= S_DIV_TA;
							end else begin
								t0_q    <= quo_nx;
								state_q <= S_SUM_T1;
							end
						end else begin
							div_num_q <= {div_num_q[62:0], 1'b0};
							div_rem_q <= rem_nx;
							cnt_q     <= cnt_q + 1'b1;
						end
					end
					S_TC_SET: begin
						div_num_q <= 64'(diff) << FRAC_BITS;
						div_den_q <= {1'b0, v_eff};
						div_rem_q <= '0;
						cnt_q     <= '0;
						state_q   <= S_DIV_TC;
					end
					S_SUM_T1: begin
						t1_q    <= t0_q + tc_q;
						plo_q   <= prod;
						state_q <= S_SUM_T2;
					end
					S_SUM_T2: begin
						t2_q    <= t1_q + t0_q;
						phi_q   <= prod;
						state_q <= S_BASE;
					end
					S_BASE: begin
						base_q  <= (plo_q + {phi_q[31:0], 32'b0}) >> (FRAC_BITS + 1);
						state_q <= S_IDLE;
					end
					S_IDLE: begin
					end
					default: begin
						state_q <= S_MUL_DA;
					end
				endcase
			end
		end
	end

	assign busy = (state_q != S_IDLE);

	assign prof.acc_mag  = a_eff;
	assign prof.vp       = vp_q;
	assign prof.dist_mag = dist_mag;
	assign prof.rev      = md_q[31];
	assign prof.t0       = t0_q;
	assign prof.t1       = t1_q;
	assign prof.t2       = t2_q;
	assign prof.base     = base_q;
endmodule

/* hdl/tps_front.sv */
// Front end: classifies a sample time into its profile phase and forms the
// time operand for the back end. Depends on tps_pkg.
module tps_front (
	input  logic              [31:0] sample_time,
	input  tps_pkg::profile_t        prof,
	output tps_pkg::item_t           item
);
	import tps_pkg::*;

	logic [63:0] tt, rem_t, dt;

	assign tt    = {32'b0, sample_time};
	assign rem_t = prof.t2 - tt;
	assign dt    = tt - prof.t0;

	always_comb begin
		item.x = '0;
		if (sample_time[31]) begin
			item.phase = PH_NEG;
		end else if (tt > prof.t2) begin
			item.phase = PH_DONE;
		end else if (tt < prof.t0) begin
			item.phase = PH_ACC;
			item.x     = sample_time[30:0];
		end else if (tt > prof.t1) begin
			item.phase = PH_DEC;
			item.x     = rem_t[30:0];
		end else begin
			item.phase = PH_CRU;
			item.x     = dt[30:0];
		end
	end
endmodule

/* hdl/tps_back.sv */
// Back end: two multiply stages that turn a classified sample into
// position, velocity and acceleration. Depends on tps_pkg.
module tps_back #(
	parameter int FRAC_BITS = 16,
	parameter int OUT_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tps_pkg::profile_t              prof,
	input  tps_pkg::item_t                 item,
	input  logic                           item_valid,
	input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
	output logic                           item_pop,
	output tps_pkg::result_t               res,
	output logic                           res_valid
);
	import tps_pkg::*;

	localparam int CW = $clog2(OUT_DEPTH + 1) + 1;

	logic        valid_s1, valid_s2;
	phase_t      phase_s1, phase_s2;
	logic [30:0] x_s1;
	logic [62:0] m1_s1;
	logic [31:0] op_a;
	logic [62:0] m1_nx;
	logic [30:0] vel31;
	logic [61:0] m2_s2;
	logic [31:0] vel_s2;
	logic [63:0] cpos_s2;
	logic [61:0] drop;
	logic [63:0] pos64, dist64;
	logic [31:0] pos_mag, vel_mag, acc_mag;
	logic        acc_neg;

	// pop only with room for everything already in the two stages
	assign item_pop = item_valid &&
		((CW'(out_count) + CW'(valid_s1) + CW'(valid_s2)) < CW'(OUT_DEPTH));

	assign op_a  = (item.phase == PH_CRU) ? prof.vp : {1'b0, prof.acc_mag};
	assign m1_nx = {31'b0, op_a} * {32'b0, item.x};
	assign vel31 = m1_s1[FRAC_BITS +: 31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= item_pop;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		phase_s1 <= item.phase;
		x_s1     <= item.x;
		m1_s1    <= m1_nx;
		phase_s2 <= phase_s1;
		m2_s2    <= {31'b0, vel31} * {31'b0, x_s1};
		vel_s2   <= (phase_s1 == PH_CRU) ? prof.vp : {1'b0, vel31};
		cpos_s2  <= prof.base + {1'b0, m1_s1 >> FRAC_BITS};
	end

	assign drop   = m2_s2 >> (FRAC_BITS + 1);
	assign dist64 = {32'b0, prof.dist_mag};

	always_comb begin
		pos64   = '0;
		vel_mag = '0;
		acc_mag = '0;
		acc_neg = 1'b0;
		unique case (phase_s2)
			PH_NEG: begin
			end
			PH_DONE: begin
				pos64 = dist64;
			end
			PH_ACC: begin
				pos64   = {2'b0, drop};
				vel_mag = vel_s2;
				acc_mag = {1'b0, prof.acc_mag};
			end
			PH_DEC: begin
				pos64   = ({2'b0, drop} > dist64) ? '0 : dist64 - {2'b0, drop};
				vel_mag = vel_s2;
				acc_mag = {1'b0, prof.acc_mag};
				acc_neg = 1'b1;
			end
			PH_CRU: begin
				pos64   = cpos_s2;
				vel_mag = vel_s2;
			end
			default: begin
			end
		endcase
	end

	assign pos_mag   = (pos64 > dist64) ? prof.dist_mag : pos64[31:0];
	assign res.pos   = apply_sign(pos_mag, prof.rev);
	assign res.vel   = apply_sign(vel_mag, prof.rev);
	assign res.acc   = apply_sign(acc_mag, prof.rev ^ acc_neg);
	assign res_valid = valid_s2;
endmodule

/* hdl/trapezoidal_profile_sampler.sv */
// Trapezoidal motion profile sampler. After reset and after every write to
// a defined register the block plans the profile (peak velocity, phase
// times) with one shared multiplier, a one-bit-per-cycle square root and a
// one-bit-per-cycle 64-bit divider; full stays high while planning. Once
// planned, one sample time is taken per clock while the sample queue has
// room: the front end classifies it into a phase and queues it, the back
// end runs two registered multiply stages and writes the result queue; a
// result passes the sample queue and both stages before it can be popped.
// Depends on tps_pkg, tps_setup, tps_front, tps_fifo, tps_back.
`include "assert_macros.svh"

module trapezoidal_profile_sampler #(
	parameter int FRAC_BITS = tps_pkg::FRAC_BITS_DEF,
	parameter int MID_DEPTH = tps_pkg::MID_DEPTH_DEF,
	parameter int OUT_DEPTH = tps_pkg::OUT_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// sample side
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] sample_time,
	// result side
	input  logic               pop,
	output logic               empty,
	output logic signed [31:0] position,
	output logic signed [31:0] velocity,
	output logic signed [31:0] acceleration,
	// register writes
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [31:0]        wr_data
);
	import tps_pkg::*;

	localparam int IW = $bits(item_t);
	localparam int RW = $bits(result_t);

	profile_t prof;
	logic     busy;
	item_t    front_item, mid_item;
	logic     mid_push, mid_pop, mid_empty, mid_full;
	logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
	logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
	result_t  back_res, out_res;
	logic     back_push, out_full;
	logic     cfg_write;

	tps_setup #(.FRAC_BITS(FRAC_BITS)) u_setup (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.busy     (busy),
		.prof     (prof)
	);

	tps_front u_front (
		.sample_time (sample_time),
		.prof        (prof),
		.item        (front_item)
	);

	// a transaction is taken only once the profile is planned
	assign full     = busy || mid_full;
	assign mid_push = push && !full;

	tps_fifo #(.W(IW), .DEPTH(MID_DEPTH)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (front_item),
		.pop    (mid_pop),
		.rdata  (mid_item),
		.count  (mid_count),
		.empty  (mid_empty),
		.full   (mid_full)
	);

	tps_back #(.FRAC_BITS(FRAC_BITS), .OUT_DEPTH(OUT_DEPTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.prof       (prof),
		.item       (mid_item),
		.item_valid (!mid_empty && mid_count != '0),
		.out_count  (out_count),
		.item_pop   (mid_pop),
		.res        (back_res),
		.res_valid  (back_push)
	);

	tps_fifo #(.W(RW), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (back_push),
		.wdata  (back_res),
		.pop    (pop),
		.rdata  (out_res),
		.count  (out_count),
		.empty  (empty),
		.full   (out_full)
	);

	assign position     = out_res.pos;
	assign velocity     = out_res.vel;
	assign acceleration = out_res.acc;

	// writes to defined registers restart planning
	assign cfg_write = wr_en && (wr_index == REG_MAX_VELOCITY
		|| wr_index == REG_MAX_ACCELERATION || wr_index == REG_MOVE_DISTANCE);

	// the back end reserves result queue space before it pops
	`ASSERT_NEVER(a_out_overflow, clk, arst_n, back_push && out_full)
	`ASSERT_NEVER(a_mid_underflow, clk, arst_n, mid_pop && mid_empty)
	`ASSERT_AT(a_cfg_replans, clk, arst_n, cfg_write |=> busy)
endmodule

/* bench/tb.sv */
// Testbench for trapezoidal_profile_sampler: samples driven through the push side,
// results checked field by field against an in-bench profile calculator.
// Depends on tps_pkg and the sampler RTL.
`timescale 1ns / 100ps

module tb;
	import tps_pkg::*;

	typedef struct {
		logic [31:0] pos;
		logic [31:0] vel;
		logic [31:0] acc;
	} motion_t;

	// planned profile: magnitudes and phase times, all 64-bit, and the reverse flag
	typedef struct {
		bit [63:0] v, a, d, vp, t0, t1, t2;
		bit        rev;
	} plan_t;

	localparam int FB = FRAC_BITS_DEF;

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	logic signed [31:0] sample_time;
	logic              pop;
	logic              empty;
	logic signed [31:0] position;
	logic signed [31:0] velocity;
	logic signed [31:0] acceleration;
	logic              wr_en;
	logic [1:0]        wr_index;
	logic [31:0]       wr_data;

	// shadow registers, updated once set_profile has written all three
	bit [30:0] vel_limit;
	bit [30:0] acc_limit;
	bit [31:0] dist_reg;

	motion_t expected_motion[$];
	bit      failed;
	bit      quiet;    // no idling on either side while set

	trapezoidal_profile_sampler u_top (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .sample_time(sample_time),
		.pop(pop), .empty(empty),
		.position(position), .velocity(velocity), .acceleration(acceleration),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// floor square root, found one result bit at a time by trial squaring
	function automatic bit [63:0] floor_sqrt(bit [63:0] x);
		bit [63:0] r;
		bit [63:0] cand;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			cand = r | (64'd1 << b);
			if (cand * cand <= x)
				r = cand;
		end
		return r;
	endfunction

	function automatic plan_t plan_move();
		plan_t p;
		bit [63:0] tc;
		bit [31:0] neg_d;
		p.v = (vel_limit == 0) ? 64'd1 : 64'(vel_limit);
		p.a = (acc_limit == 0) ? 64'd1 : 64'(acc_limit);
		p.rev = dist_reg[31];
		neg_d = ~dist_reg + 32'd1;
		p.d = p.rev ? 64'(neg_d) : 64'(dist_reg);
		if (p.rev && p.d == 0)
			p.d = 64'd1 << 31;
		if (p.d * p.a < p.v * p.v) begin
			// triangle: cruise collapses to one instant at the apex
			p.vp = floor_sqrt(p.d * p.a);
			tc = 0;
		end else begin
			p.vp = p.v;
			tc = ((p.d - (p.v * p.v) / p.a) << FB) / p.v;
		end
		p.t0 = (p.vp << FB) / p.a;
		p.t1 = p.t0 + tc;
		p.t2 = p.t1 + p.t0;
		return p;
	endfunction

	function automatic logic [31:0] signed_mag(bit [63:0] mag, bit neg);
		bit [31:0] m;
		m = mag[31:0];
		return neg ? (~m + 32'd1) : m;
	endfunction

	function automatic motion_t sample_motion(logic [31:0] traw);
		plan_t p;
		motion_t m;
		bit [63:0] t, pos, vel, acc, r, drop;
		bit decel;
		p = plan_move();
		pos = 0; vel = 0; acc = 0; decel = 0;
		m.pos = 0; m.vel = 0; m.acc = 0;
		if (traw[31])
			return m;    // before the move starts: all zero
		t = 64'(traw);
		if (t > p.t2) begin
			pos = p.d;
		end else if (t < p.t0) begin
			vel = (p.a * t) >> FB;
			acc = p.a;
			pos = (vel * t) >> (FB + 1);
		end else if (t > p.t1) begin
			r = p.t2 - t;
			vel = (p.a * r) >> FB;
			acc = p.a;
			decel = 1;
			drop = (vel * r) >> (FB + 1);
			pos = (drop > p.d) ? 0 : p.d - drop;
		end else begin
			// cruise, boundaries T0 and T1 included
			vel = p.vp;
			pos = ((p.vp * p.t0) >> (FB + 1)) + ((p.vp * (t - p.t0)) >> FB);
		end
		if (pos > p.d)
			pos = p.d;
		m.pos = signed_mag(pos, p.rev);
		m.vel = signed_mag(vel, p.rev);
		m.acc = signed_mag(acc, p.rev != decel);
		return m;
	endfunction

	// result side: random pop, compare each popped transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n)
			pop <= quiet || ($urandom_range(0, 99) >= 12);
	end

	always @(posedge clk) begin
		motion_t e;
		if (arst_n && pop && !empty) begin
			if (expected_motion.size() == 0) begin
				$display("%0t: unexpected result pos=%h vel=%h acc=%h", $time,
					position, velocity, acceleration);
				failed = 1;
			end else begin
				e = expected_motion.pop_front();
				if (position !== e.pos) begin
					$display("%0t: position exp %h got %h", $time, e.pos, position);
					failed = 1;
				end
				if (velocity !== e.vel) begin
					$display("%0t: velocity exp %h got %h", $time, e.vel, velocity);
					failed = 1;
				end
				if (acceleration !== e.acc) begin
					$display("%0t: acceleration exp %h got %h", $time, e.acc, acceleration);
					failed = 1;
				end
			end
		end
	end

	// one sample transaction; entered and left at a clock edge
	task automatic send_sample(logic [31:0] t);
		while (!quiet && $urandom_range(0, 99) < 12) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		sample_time <= t;
		do @(posedge clk); while (full);
		expected_motion.push_back(sample_motion(t));
	endtask

	// registers change only with the pipe drained
	task automatic set_profile(logic [31:0] vmax, logic [31:0] amax, logic [31:0] dist_val);
		push <= 1'b0;
		while (expected_motion.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		wr_en <= 1'b1;
		wr_index <= REG_MAX_VELOCITY;
		wr_data <= vmax;
		@(posedge clk);
		wr_index <= REG_MAX_ACCELERATION;
		wr_data <= amax;
		@(posedge clk);
		wr_index <= REG_MOVE_DISTANCE;
		wr_data <= dist_val;
		@(posedge clk);
		wr_en <= 1'b0;
		vel_limit = vmax[30:0];
		acc_limit = amax[30:0];
		dist_reg = dist_val;
	endtask

	// times around every phase edge of the current profile
	task automatic sweep_edges();
		plan_t p;
		bit [63:0] marks[4];
		p = plan_move();
		marks[0] = 0; marks[1] = p.t0; marks[2] = p.t1; marks[3] = p.t2;
		foreach (marks[i])
			for (int k = -1; k <= 1; k++)
				if (marks[i] + 64'(k) < 64'h8000_0000)
					send_sample(32'(marks[i] + 64'(k)));
	endtask

	function automatic logic [31:0] rand_rate();
		return $urandom >> $urandom_range(0, 31);
	endfunction

	function automatic logic [31:0] rand_time();
		plan_t p;
		bit [63:0] span;
		p = plan_move();
		span = (p.t2 > 64'h7FFF_FFF0) ? 64'h7FFF_FFF0 : p.t2 + 8;
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 32'(p.t0) + $urandom_range(0, 4) - 2;
			2: return 32'(p.t1) + $urandom_range(0, 4) - 2;
			3: return 32'(p.t2) + $urandom_range(0, 4) - 2;
			default: return 32'(({$urandom, $urandom}) % (span + 1));
		endcase
	endfunction

	task automatic test_reset_profile();
		// defaults: unit rates, zero distance
		send_sample(32'd0);
		send_sample(32'd65536);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
	endtask

	task automatic test_directed_profiles();
		// trapezoid forward, triangle backward, most negative distance, zero rates
		set_profile(32'h0001_0000, 32'h0002_0000, 32'h0004_0000);
		sweep_edges();
		set_profile(32'h0010_0000, 32'h0001_0000, 32'hFFFF_0000);
		sweep_edges();
		set_profile(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		send_sample(32'hFFFF_FFFF);
		sweep_edges();
		set_profile(32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
		send_sample(32'd1);
		send_sample(32'h7FFF_FFFF);
	endtask

	task automatic test_random_profiles();
		logic [31:0] d;
		for (int s = 0; s < 28; s++) begin
			d = $urandom >> $urandom_range(0, 24);
			if ($urandom_range(0, 1))
				d = ~d + 32'd1;
			set_profile(rand_rate(), rand_rate(), d);
			quiet = (s >= 10 && s < 14);
			for (int i = 0; i < 48; i++)
				send_sample(rand_time());
		end
		quiet = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		sample_time = '0;
		wr_en = 1'b0;
		wr_index = REG_MAX_VELOCITY;
		wr_data = '0;
		failed = 0;
		quiet = 0;
		vel_limit = 31'h0001_0000;
		acc_limit = 31'h0001_0000;
		dist_reg = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_profile();
		test_directed_profiles();
		test_random_profiles();
		push <= 1'b0;
		while (expected_motion.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (!failed)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* trapezoidal_profile_sampler.f */
+incdir+hdl
hdl/tps_pkg.sv
hdl/tps_fifo.sv
hdl/tps_setup.sv
hdl/tps_front.sv
hdl/tps_back.sv
hdl/trapezoidal_profile_sampler.sv
bench/tb.sv
